// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both forms assume a clock named clk_i and an
// active-low reset named rst_ni in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PSQ_ASSERT(lbl, prop, msg)
`define PSQ_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/psq_pkg.sv =====
package psq_pkg;

  localparam int unsigned MAX_WAITERS = 16;
  localparam int unsigned PRIO_BITS   = 16;
  localparam int unsigned TAG_BITS    = 8;
  localparam int unsigned IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned LEN_W       = $clog2(MAX_WAITERS + 1);

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } psq_entry_t;

  // Request from the control logic to the queue sequencer.
  typedef struct packed {
    logic       start;
    logic       pop;
    logic       clear;
    psq_entry_t entry;
  } psq_cmd_t;

  // Status from the queue sequencer; entry carries the popped head when done.
  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] len;
    psq_entry_t       entry;
  } psq_sts_t;

endpackage

// ===== sv/priority_semaphore_queue.sv =====
// Counting semaphore with a priority-ordered wait queue.
// Requests enter on req_valid_i/req_ready_o: req_type_i selects wait or signal, and a
// wait carries priority_req_i and waiter_tag_i. Every request gives one response on
// rsp_valid_o/rsp_ready_i with status_o, the woken waiter's tag and priority, and the
// count after the request. cfg_valid_i/cfg_ready_o writes initial_count_i, which loads
// the count and empties the queue; it is taken only while no request is in flight.
// A request that does not touch the queue goes from IDLE to HOLD, and its response
// is registered from HOLD once the output register is free. A pop and an insert
// wait in QUEUE for the sequencer: a pop reads the head, and an insert passes every
// queued waiter with a lower priority value. One comparator walks the queue RAM from
// the head, one entry per cycle, moving each passed entry up by one place.
// Only one request is in flight at a time; ready is low until its result has moved
// into the output register. A held response does not block the next request, but
// that request's result waits until the receiver takes the earlier one.
// Reset loads a count of zero and an empty queue; there is no clearing pass.
`include "assert_macros.svh"

module priority_semaphore_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [14:0]        initial_count_i,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               req_type_i,
  input  logic [15:0]        priority_req_i,
  input  logic [7:0]         waiter_tag_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [2:0]         status_o,
  output logic [7:0]         woken_tag_o,
  output logic [15:0]        woken_priority_o,
  output logic signed [15:0] count_after_o
);

  localparam int unsigned CNT_W = 16;
  localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sd32767;

  localparam logic REQ_WAIT = 1'b0;

  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_WOKEN     = 3'd2;
  localparam logic [2:0] ST_NO_WAITER = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_SATURATED = 3'd5;

  localparam logic [1:0] FSM_IDLE  = 2'd0;
  localparam logic [1:0] FSM_QUEUE = 2'd1;
  localparam logic [1:0] FSM_HOLD  = 2'd2;

  logic [1:0]              fsm_q, fsm_d;
  logic signed [CNT_W-1:0] count_q, count_d;
  logic                    out_valid_q, out_valid_d;

  logic [2:0]              res_status_q;
  logic [7:0]              res_tag_q;
  logic [15:0]             res_prio_q;
  logic [2:0]              out_status_q;
  logic [7:0]              out_tag_q;
  logic [15:0]             out_prio_q;
  logic signed [CNT_W-1:0] out_count_q;

  logic                    req_acc, cfg_acc, out_load, res_load_wake;
  logic                    queue_full, count_nonpos, inc_nonpos;
  logic signed [CNT_W-1:0] count_dec, count_inc, dec_count;
  logic [2:0]              dec_status;
  logic                    dec_queue, dec_pop;
  psq_pkg::psq_entry_t     wait_entry;
  psq_pkg::psq_cmd_t       cmd;
  psq_pkg::psq_sts_t       sts;

  assign cfg_ready_o = (fsm_q == FSM_IDLE);
  assign req_ready_o = (fsm_q == FSM_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign req_acc     = req_valid_i && req_ready_o;

  assign wait_entry.prio = priority_req_i[psq_pkg::PRIO_BITS-1:0];
  assign wait_entry.tag  = waiter_tag_i[psq_pkg::TAG_BITS-1:0];

  assign count_dec    = count_q - 16'sd1;
  assign count_inc    = count_q + 16'sd1;
  assign count_nonpos = count_q[CNT_W-1] || (count_q == '0);
  assign inc_nonpos   = count_inc[CNT_W-1] || (count_inc == '0);
  assign queue_full   = (sts.len == psq_pkg::LEN_W'(psq_pkg::MAX_WAITERS));

  always_comb begin
    dec_count  = count_q;
    dec_status = ST_NO_WAITER;
    dec_queue  = 1'b0;
    dec_pop    = 1'b0;
    if (req_type_i == REQ_WAIT) begin
      if (count_nonpos) begin
        if (queue_full) begin
          dec_status = ST_FULL;
        end else begin
          dec_count  = count_dec;
          dec_status = ST_QUEUED;
          dec_queue  = 1'b1;
        end
      end else begin
        dec_count  = count_dec;
        dec_status = ST_GRANTED;
      end
    end else begin
      if (count_q >= COUNT_MAX) begin
        dec_count  = COUNT_MAX;
        dec_status = ST_SATURATED;
      end else begin
        dec_count = count_inc;
        // A signal that leaves the count at zero or below hands the semaphore on.
        if (inc_nonpos && (sts.len != '0)) begin
          dec_status = ST_WOKEN;
          dec_queue  = 1'b1;
          dec_pop    = 1'b1;
        end
      end
    end
  end

  assign cmd.start = req_acc && dec_queue;
  assign cmd.pop   = dec_pop;
  assign cmd.clear = cfg_acc;
  assign cmd.entry = wait_entry;

  psq_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .sts_o (sts)
  );

  assign out_load      = (fsm_q == FSM_HOLD) && (!out_valid_q || rsp_ready_i);
  assign res_load_wake = (fsm_q == FSM_QUEUE) && sts.done && (res_status_q == ST_WOKEN);

  always_comb begin
    fsm_d       = fsm_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (fsm_q)
      FSM_IDLE: begin
        if (cfg_acc) begin
          count_d = signed'({1'b0, initial_count_i});
        end else if (req_acc) begin
          count_d = dec_count;
          fsm_d   = dec_queue ? FSM_QUEUE : FSM_HOLD;
        end
      end
      FSM_QUEUE: begin
        if (sts.done) begin
          fsm_d = FSM_HOLD;
        end
      end
      FSM_HOLD: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          fsm_d       = FSM_IDLE;
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      res_status_q <= dec_status;
      res_tag_q    <= '0;
      res_prio_q   <= '0;
    end else if (res_load_wake) begin
      res_tag_q  <= 8'(sts.entry.tag);
      res_prio_q <= 16'(sts.entry.prio);
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_tag_q    <= res_tag_q;
      out_prio_q   <= res_prio_q;
      out_count_q  <= count_q;
    end
  end

  assign rsp_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign woken_tag_o      = out_tag_q;
  assign woken_priority_o = out_prio_q;
  assign count_after_o    = out_count_q;

  `PSQ_ASSERT(a_busy_after_req, (req_valid_i && req_ready_o) |=> !req_ready_o,
              "request accepted while the previous one was still in flight")
  `PSQ_ASSERT_IMPL(a_done_only_queue, sts.done, fsm_q == FSM_QUEUE,
                   "queue sequencer finished without an outstanding request")
  `PSQ_ASSERT_IMPL(a_empty_when_pos, (fsm_q == FSM_IDLE) && !count_q[CNT_W-1],
                   sts.len == '0, "waiters queued while the count is not negative")
  `PSQ_ASSERT_IMPL(a_len_matches, (fsm_q == FSM_IDLE) && count_q[CNT_W-1],
                   (CNT_W'(sts.len) + count_q) == '0,
                   "queue length differs from the negative count")

endmodule

// ===== sv/psq_ram.sv =====
module psq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/psq_seq.sv =====
module psq_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psq_pkg::psq_cmd_t  cmd_i,
  output psq_pkg::psq_sts_t  sts_o
);

  // The queue is stored head last: the head sits at index len-1 and the tail at 0,
  // so a pop is a single read and an insert walks down from the head.
  localparam logic [1:0] SQ_IDLE = 2'd0;
  localparam logic [1:0] SQ_SCAN = 2'd1;
  localparam logic [1:0] SQ_HEAD = 2'd2;
  localparam logic [1:0] SQ_POP  = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [psq_pkg::LEN_W-1:0]    len_q, len_d;
  logic [psq_pkg::IDX_W-1:0]    idx_q, idx_d;
  psq_pkg::psq_entry_t          new_q, new_d;

  logic                         wr_en, rd_en, done;
  logic [psq_pkg::IDX_W-1:0]    wr_addr, rd_addr, last_idx;
  psq_pkg::psq_entry_t          wr_data, rd_entry;
  logic [$bits(psq_pkg::psq_entry_t)-1:0] rd_data;

  assign last_idx = psq_pkg::IDX_W'(len_q - 1'b1);
  assign rd_entry = rd_data;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    idx_d   = idx_q;
    new_d   = new_q;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = new_q;
    rd_en   = 1'b0;
    rd_addr = idx_q;
    done    = 1'b0;
    unique case (state_q)
      SQ_IDLE: begin
        if (cmd_i.clear) begin
          len_d = '0;
        end else if (cmd_i.start) begin
          new_d = cmd_i.entry;
          if (cmd_i.pop) begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
            state_d = SQ_POP;
          end else if (len_q == '0) begin
            state_d = SQ_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
            idx_d   = last_idx;
            state_d = SQ_SCAN;
          end
        end
      end
      SQ_SCAN: begin
        // A stored entry with a strictly lower value stays ahead and moves up one
        // place; the newcomer goes in front of the first equal or greater one.
        wr_en   = 1'b1;
        wr_addr = idx_q + 1'b1;
        if (new_q.prio > rd_entry.prio) begin
          wr_data = rd_entry;
          if (idx_q == '0) begin
            state_d = SQ_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q - 1'b1;
            idx_d   = idx_q - 1'b1;
          end
        end else begin
          wr_data = new_q;
          len_d   = len_q + 1'b1;
          done    = 1'b1;
          state_d = SQ_IDLE;
        end
      end
      SQ_HEAD: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = new_q;
        len_d   = len_q + 1'b1;
        done    = 1'b1;
        state_d = SQ_IDLE;
      end
      SQ_POP: begin
        len_d   = len_q - 1'b1;
        done    = 1'b1;
        state_d = SQ_IDLE;
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    new_q <= new_d;
  end

  psq_ram #(
    .WIDTH($bits(psq_pkg::psq_entry_t)),
    .DEPTH(psq_pkg::MAX_WAITERS)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign sts_o.done  = done;
  assign sts_o.len   = len_q;
  assign sts_o.entry = rd_entry;

endmodule
